// ----- hdl/chained_hash_table_defines.svh -----
// Assertion macros for the chained hash table.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef CHAINED_HASH_TABLE_DEFINES_SVH
`define CHAINED_HASH_TABLE_DEFINES_SVH
`ifndef SYNTH
`define CHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define CHT_ASSERT(lbl, prop, msg)
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/cht_pkg.sv -----
// Shared constants and controller/datapath interface types for the hash table.
// No dependencies.
package cht_pkg;
  localparam int NUM_BUCKETS_DEF = 256;
  localparam int NUM_ENTRIES_DEF = 256;
  localparam int HASH_W          = 32;
  localparam int DATA_W          = 32;
  localparam int OP_W            = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 9;
  localparam int DIV_STEPS       = 32;
  localparam int DIV_CNT_W       = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_GET    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_DUP    = 2'd1;

  typedef struct packed {
    logic clr_step;   // one step of the post-reset clearing pass
    logic load;       // capture request
    logic div_step;   // one remainder bit
    logic head_load;  // take bucket head as chain cursor
    logic advance;    // no match: prev <= cur, cur <= next
    logic unlink;     // match: splice out cur and release it
    logic pop;        // take a slot off the free stack
    logic put;        // write the new entry at the bucket head
    logic set_status; // pool exhausted
    logic set_found;  // get hit: latch data
  } cht_cmd_t;

  typedef struct packed {
    logic            clr_last;
    logic            div_last;
    logic            cur_none;
    logic            key_match;
    logic            head_none;
    logic            fc_zero;
    logic            dup;
    logic [OP_W-1:0] op;
  } cht_sts_t;
endpackage

// ----- hdl/cht_datapath.sv -----
// Datapath of the hash table: config registers, remainder unit, chain cursor,
// bucket/entry/free-stack memories and result registers. Uses cht_pkg.
module cht_datapath #(
  parameter int NUM_BUCKETS = 256,
  parameter int NUM_ENTRIES = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cht_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [cht_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic [cht_pkg::OP_W-1:0]            opcode_i,
  input  logic [cht_pkg::HASH_W-1:0]          key_hash_i,
  input  logic [cht_pkg::DATA_W-1:0]          data_value_i,
  input  cht_pkg::cht_cmd_t                   cmd_i,
  output cht_pkg::cht_sts_t                   sts_o,
  output logic                                found_o,
  output logic [cht_pkg::DATA_W-1:0]          read_data_o,
  output logic                                status_o
);
  import cht_pkg::*;

  localparam int IW    = $clog2(NUM_ENTRIES);
  localparam int PW    = $clog2(NUM_ENTRIES + 1);
  localparam int BIW   = $clog2(NUM_BUCKETS);
  localparam int DW    = $clog2(NUM_BUCKETS + 1);
  localparam int CLR_N = (NUM_BUCKETS > NUM_ENTRIES) ? NUM_BUCKETS : NUM_ENTRIES;
  localparam int CW    = $clog2(CLR_N);
  localparam logic [PW-1:0] NONE = PW'(NUM_ENTRIES);

  logic [CFG_DATA_W-1:0] bc_q;
  logic                  dup_q;
  logic [OP_W-1:0]       op_q;
  logic [HASH_W-1:0]     hash_q, dvd_q;
  logic [DATA_W-1:0]     data_q;
  logic [DW:0]           rem_q, rem_sh, rem_d;
  logic [DW-1:0]         modulus;
  logic [DIV_CNT_W-1:0]  dcnt_q;
  logic [PW-1:0]         cur_q, prev_q, head_q, fc_q;
  logic [CW-1:0]         clr_q;
  logic                  found_q, status_q;
  logic [DATA_W-1:0]     rdata_q;
  logic [BIW-1:0]        bkt;

  logic [PW-1:0]     head_mem [NUM_BUCKETS];
  logic [HASH_W-1:0] key_mem  [NUM_ENTRIES];
  logic [DATA_W-1:0] val_mem  [NUM_ENTRIES];
  logic [PW-1:0]     link_mem [NUM_ENTRIES];
  logic [IW-1:0]     stk_mem  [NUM_ENTRIES];

  logic [PW-1:0]     head_rd, link_rd;
  logic [HASH_W-1:0] key_rd;
  logic [DATA_W-1:0] val_rd;
  logic [IW-1:0]     stk_rd;

  // zero or out-of-range bucket count falls back to the full table
  assign modulus = (bc_q == '0 || 32'(bc_q) > NUM_BUCKETS) ? DW'(NUM_BUCKETS) : DW'(bc_q);
  assign rem_sh  = {rem_q[DW-1:0], dvd_q[HASH_W-1]};
  assign rem_d   = (rem_sh >= {1'b0, modulus}) ? rem_sh - {1'b0, modulus} : rem_sh;
  assign bkt     = rem_q[BIW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q     <= CFG_DATA_W'(256);
      dup_q    <= 1'b0;
      fc_q     <= PW'(NUM_ENTRIES);
      clr_q    <= '0;
      found_q  <= 1'b0;
      status_q <= 1'b0;
      rdata_q  <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_BUCKET_COUNT) bc_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == CFG_ALLOW_DUP) dup_q <= cfg_wdata_i[0];
      if (cmd_i.clr_step) clr_q <= clr_q + CW'(1);
      if (cmd_i.load) begin
        found_q  <= 1'b0;
        status_q <= 1'b0;
        rdata_q  <= '0;
      end
      if (cmd_i.unlink) begin
        // a replacement during insert does not count as found
        if (op_q == OP_REMOVE) found_q <= 1'b1;
        if (fc_q < PW'(NUM_ENTRIES)) fc_q <= fc_q + PW'(1);
      end
      if (cmd_i.pop) fc_q <= fc_q - PW'(1);
      if (cmd_i.set_status) status_q <= 1'b1;
      if (cmd_i.set_found) begin
        found_q <= 1'b1;
        rdata_q <= val_rd;
      end
    end
  end

  // request fields, remainder and chain cursor
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      hash_q <= key_hash_i;
      dvd_q  <= key_hash_i;
      data_q <= data_value_i;
      rem_q  <= '0;
      dcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= rem_d;
      dvd_q  <= {dvd_q[HASH_W-2:0], 1'b0};
      dcnt_q <= dcnt_q + DIV_CNT_W'(1);
    end
    if (cmd_i.head_load) begin
      cur_q  <= head_rd;
      head_q <= head_rd;
      prev_q <= NONE;
    end
    if (cmd_i.advance) begin
      prev_q <= cur_q;
      cur_q  <= link_rd;
    end
    if (cmd_i.unlink) begin
      cur_q <= link_rd;
      if (prev_q == NONE) head_q <= link_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    head_rd <= head_mem[bkt];
    if (cmd_i.clr_step && 32'(clr_q) < NUM_BUCKETS) head_mem[clr_q[BIW-1:0]] <= NONE;
    else if (cmd_i.unlink && prev_q == NONE) head_mem[bkt] <= link_rd;
    else if (cmd_i.put) head_mem[bkt] <= PW'(stk_rd);
  end

  always_ff @(posedge clk_i) begin
    key_rd  <= key_mem[cur_q[IW-1:0]];
    val_rd  <= val_mem[cur_q[IW-1:0]];
    link_rd <= link_mem[cur_q[IW-1:0]];
    if (cmd_i.put) begin
      key_mem[stk_rd] <= hash_q;
      val_mem[stk_rd] <= data_q;
    end
    if (cmd_i.unlink && prev_q != NONE) link_mem[prev_q[IW-1:0]] <= link_rd;
    else if (cmd_i.put) link_mem[stk_rd] <= head_q;
  end

  always_ff @(posedge clk_i) begin
    stk_rd <= stk_mem[fc_q[IW-1:0]];
    if (cmd_i.clr_step && 32'(clr_q) < NUM_ENTRIES)
      stk_mem[clr_q[IW-1:0]] <= IW'(NUM_ENTRIES - 1) - clr_q[IW-1:0];
    else if (cmd_i.unlink && fc_q < PW'(NUM_ENTRIES)) stk_mem[fc_q[IW-1:0]] <= cur_q[IW-1:0];
  end

  assign sts_o.clr_last  = (clr_q == CW'(CLR_N - 1));
  assign sts_o.div_last  = (dcnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts_o.cur_none  = (cur_q >= NONE);
  assign sts_o.key_match = (key_rd == hash_q);
  assign sts_o.head_none = (head_rd == NONE);
  assign sts_o.fc_zero   = (fc_q == '0);
  assign sts_o.dup       = dup_q;
  assign sts_o.op        = op_q;

  assign found_o     = found_q;
  assign read_data_o = rdata_q;
  assign status_o    = status_q;
endmodule

// ----- hdl/cht_ctrl.sv -----
// Controller state machine for the hash table: sequences clearing, remainder,
// chain walk and allocation. Uses cht_pkg and chained_hash_table_defines.svh.
`include "chained_hash_table_defines.svh"
module cht_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic [cht_pkg::OP_W-1:0]     opcode_i,
  input  cht_pkg::cht_sts_t            sts_i,
  output cht_pkg::cht_cmd_t            cmd_o,
  output logic                         busy,
  output logic                         done_o
);
  import cht_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_HEAD  = 4'd3;
  localparam logic [3:0] S_HEADW = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_ALLOC = 4'd7;
  localparam logic [3:0] S_POPW  = 4'd8;
  localparam logic [3:0] S_PUT   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_q, state_d;
  logic       walk_all, is_insert, is_get;

  assign is_insert = (sts_i.op == OP_INSERT);
  assign is_get    = (sts_i.op == OP_GET);
  assign walk_all  = (sts_i.op == OP_REMOVE) && sts_i.dup;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = (opcode_i == OP_INSERT || opcode_i == OP_REMOVE || opcode_i == OP_GET)
                    ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_HEAD;
      end
      S_HEAD: state_d = S_HEADW;
      S_HEADW: begin
        cmd_o.head_load = 1'b1;
        // with duplicates kept an insert skips the replacement walk
        state_d = (is_insert && (sts_i.dup || sts_i.head_none)) ? S_ALLOC : S_WALK;
      end
      S_WALK: begin
        if (sts_i.cur_none) state_d = is_insert ? S_ALLOC : S_DONE;
        else state_d = S_CMP;
      end
      S_CMP: begin
        if (!sts_i.key_match) begin
          cmd_o.advance = 1'b1;
          state_d = S_WALK;
        end else if (is_get) begin
          cmd_o.set_found = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.unlink = 1'b1;
          if (walk_all) state_d = S_WALK;
          else state_d = is_insert ? S_ALLOC : S_DONE;
        end
      end
      S_ALLOC: begin
        if (sts_i.fc_zero) begin
          cmd_o.set_status = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.pop = 1'b1;
          state_d = S_POPW;
        end
      end
      S_POPW: state_d = S_PUT;
      S_PUT: begin
        cmd_o.put = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  `CHT_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe held longer than one cycle")
  `CHT_ASSERT_NEXT(a_accept_moves, start && !busy, busy, "request accepted but block stayed idle")
  `CHT_ASSERT(a_unlink_live, !cmd_o.unlink || !sts_i.cur_none, "unlink issued on empty cursor")
  `CHT_ASSERT(a_put_has_slot, !cmd_o.pop || !sts_i.fc_zero, "pop from an empty free stack")
endmodule

// ----- hdl/chained_hash_table.sv -----
// A request runs the remainder unit, reads the bucket head and walks the chain; an insert
// then takes a slot off the free stack, or sets status_o when the pool is full. Opcode 3
// is unused. A new request is accepted in the cycle after the result, not while busy.
// The 32-step remainder unit and the one-read-per-link entry memory set the rate.
// Reset is asynchronous; afterwards a clearing pass over the bucket heads and free stack
// runs with busy high. The done_o strobe lasts one cycle; no stall.
module chained_hash_table #(
  parameter int NUM_BUCKETS = cht_pkg::NUM_BUCKETS_DEF,
  parameter int NUM_ENTRIES = cht_pkg::NUM_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cht_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cht_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           start,
  output logic                           busy,
  input  logic [cht_pkg::OP_W-1:0]       opcode_i,
  input  logic [cht_pkg::HASH_W-1:0]     key_hash_i,
  input  logic [cht_pkg::DATA_W-1:0]     data_value_i,
  output logic                           done_o,
  output logic                           found_o,
  output logic [cht_pkg::DATA_W-1:0]     read_data_o,
  output logic                           status_o
);
  import cht_pkg::*;

  cht_cmd_t cmd;
  cht_sts_t sts;

  cht_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .opcode_i,
    .sts_i(sts), .cmd_o(cmd), .busy, .done_o
  );

  cht_datapath #(.NUM_BUCKETS(NUM_BUCKETS), .NUM_ENTRIES(NUM_ENTRIES)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .opcode_i, .key_hash_i, .data_value_i,
    .cmd_i(cmd), .sts_o(sts), .found_o, .read_data_o, .status_o
  );
endmodule
